>>> hw/rtl/lzg_pkg.sv
// Shared constants, datapath opcodes and the command/status structs for the
// LZ gamma stream decompressor. No dependencies.
package lzg_pkg;

  localparam int WIN_BITS    = 16;
  localparam int WINDOW_SIZE = 1 << WIN_BITS;
  localparam int CNT_BITS    = WIN_BITS + 1;
  localparam int MAX_RUN     = 64;
  localparam int RUN_BITS    = $clog2(MAX_RUN + 1);
  localparam int ADDR_BITS   = 3;

  localparam int BUMP_HIGH = 32000;
  localparam int BUMP_MID  = 1280;
  localparam int BUMP_LOW  = 128;

  localparam logic [3:0] HDR_RESET = 4'd8;
  localparam logic [ADDR_BITS-3:0] REG_HEADER_LENGTH = '0;

  typedef enum logic [4:0] {
    DP_NOP, DP_HDR, DP_FIRST, DP_LIT, DP_ZERO, DP_RD, DP_CPY, DP_SEVEN,
    DP_LOW, DP_BIT, DP_BIT_MO1, DP_BIT_MOSH, DP_BIT_SHORT, DP_BIT_G1,
    DP_BIT_GAM, DP_BIT_REP, DP_BIT_RG, DP_BIT_LG, DP_FAIL, DP_DONE, DP_STAT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   in_ready;
    logic   zero_ph;
    logic   in_hdr;
  } lzg_cmd_t;

  typedef struct packed {
    logic held_valid;
    logic tag_avail;
    logic bit_val;
    logic hdr_zero;
    logic copy_nz;
    logic short_full;
    logic short_zero;
    logic short_bad;
    logic g_msb;
    logic g_is2;
    logic after_match;
    logic prev_bad;
    logic sev_zero;
    logic sev_bad;
    logic low_bad;
    logic done;
    logic err;
    logic emit_ok;
  } lzg_stat_t;

endpackage

>>> hw/rtl/lzg_if.sv
// Stream channel interfaces for compressed input and decompressed output.
// No dependencies.
interface lzg_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] in_byte;
  modport source (output valid, output operation, output in_byte, input ready);
  modport sink   (input valid, input operation, input in_byte, output ready);
endinterface

interface lzg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic       copy_pending;
  logic       finished;
  logic       error_flag;
  modport source (output valid, output out_byte, output byte_valid, output last,
                  output copy_pending, output finished, output error_flag, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input copy_pending, input finished, input error_flag, output ready);
endinterface

>>> hw/rtl/lzg_datapath.sv
// Datapath: history window memory, decode registers, tag shifter, config
// register and output staging. Depends on lzg_pkg and lzg_if.
module lzg_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lzg_pkg::lzg_cmd_t              cmd_i,
  output lzg_pkg::lzg_stat_t             stat_o,
  lzg_in_if.sink                         in_i,
  lzg_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lzg_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import lzg_pkg::*;

  logic [7:0]          mem_q [WINDOW_SIZE];
  logic [7:0]          rd_data_q;
  logic                held_valid_q;
  logic [7:0]          held_byte_q;
  logic [7:0]          tag_q;
  logic [3:0]          bits_left_q;
  logic [3:0]          hdr_len_q, hdr_left_q;
  logic [31:0]         gamma_q, copy_q;
  logic [CNT_BITS-1:0] mo_q, prev_q, prod_q;
  logic                prev_set_q, am_q, done_q, err_q;
  logic [WIN_BITS-1:0] wp_q;
  logic                pend_valid_q;
  logic [7:0]          pend_byte_q;
  logic                ov_q, obv_q, olast_q, ocp_q, ofin_q, oerr_q;
  logic [7:0]          ob_q;

  logic                bit_val, bit_op, emit_en, load_out, cfg_we, in_fire, emit_ok;
  logic [7:0]          emit_b;
  logic [3:0]          short_low;
  logic [6:0]          sev_off;
  logic [32:0]         gk, len33;
  logic [CNT_BITS-1:0] low_off;
  logic [31:0]         len32;
  logic [WIN_BITS-1:0] rd_idx;

  assign in_fire = in_i.valid && cmd_i.in_ready;
  assign in_i.ready = cmd_i.in_ready;
  assign emit_ok = !ov_q || out_o.ready;
  assign bit_val = (bits_left_q == 4'd0) ? held_byte_q[7] : tag_q[7];
  assign short_low = {mo_q[2:0], bit_val};
  assign sev_off = held_byte_q[7:1];
  assign gk = {1'b0, gamma_q} - (am_q ? 33'd2 : 33'd3);
  assign low_off = {gk[8:0], held_byte_q};
  assign len33 = {1'b0, gamma_q}
               + ((mo_q >= CNT_BITS'(BUMP_HIGH)) ? 33'd1 : 33'd0)
               + ((mo_q >= CNT_BITS'(BUMP_MID)) ? 33'd1 : 33'd0)
               + ((mo_q < CNT_BITS'(BUMP_LOW)) ? 33'd2 : 33'd0);
  assign len32 = len33[32] ? '1 : len33[31:0];
  assign rd_idx = wp_q - mo_q[WIN_BITS-1:0];
  assign cfg_we = psel && penable && pwrite && (paddr[ADDR_BITS-1:2] == REG_HEADER_LENGTH);
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_BITS-1:2] == REG_HEADER_LENGTH) ? {28'd0, hdr_len_q} : '0;

  always_comb begin
    bit_op = cmd_i.op inside {DP_BIT, DP_BIT_MO1, DP_BIT_MOSH, DP_BIT_SHORT, DP_BIT_G1,
                              DP_BIT_GAM, DP_BIT_REP, DP_BIT_RG, DP_BIT_LG};
    emit_en = cmd_i.op inside {DP_FIRST, DP_LIT, DP_ZERO, DP_CPY};
    case (cmd_i.op)
      DP_FIRST, DP_LIT: emit_b = held_byte_q;
      DP_CPY:           emit_b = rd_data_q;
      default:          emit_b = 8'd0;
    endcase
    load_out = (emit_en && pend_valid_q) || (cmd_i.op == DP_STAT);
  end

  always_comb begin
    stat_o.held_valid  = held_valid_q;
    stat_o.tag_avail   = (bits_left_q != 4'd0) || held_valid_q;
    stat_o.bit_val     = bit_val;
    stat_o.hdr_zero    = hdr_left_q == 4'd0;
    stat_o.copy_nz     = copy_q != 32'd0;
    stat_o.short_full  = mo_q[3];
    stat_o.short_zero  = short_low == 4'd0;
    stat_o.short_bad   = CNT_BITS'(short_low) > prod_q;
    stat_o.g_msb       = gamma_q[31];
    stat_o.g_is2       = gamma_q == 32'd2;
    stat_o.after_match = am_q;
    stat_o.prev_bad    = !prev_set_q || (prev_q > prod_q);
    stat_o.sev_zero    = sev_off == 7'd0;
    stat_o.sev_bad     = CNT_BITS'(sev_off) > prod_q;
    stat_o.low_bad     = (gk[32:9] != '0) || (low_off == '0) || (low_off > prod_q);
    stat_o.done        = done_q;
    stat_o.err         = err_q;
    stat_o.emit_ok     = emit_ok;
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      mem_q[wp_q] <= emit_b;
    end
    if (cmd_i.op == DP_RD) begin
      rd_data_q <= mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_byte_q  <= '0;
      tag_q        <= '0;
      bits_left_q  <= '0;
      hdr_len_q    <= HDR_RESET;
      hdr_left_q   <= HDR_RESET;
      gamma_q      <= 32'd1;
      copy_q       <= '0;
      mo_q         <= '0;
      prev_q       <= '0;
      prod_q       <= '0;
      prev_set_q   <= 1'b0;
      am_q         <= 1'b0;
      done_q       <= 1'b0;
      err_q        <= 1'b0;
      wp_q         <= '0;
      pend_valid_q <= 1'b0;
      pend_byte_q  <= '0;
      ov_q         <= 1'b0;
      ob_q         <= '0;
      obv_q        <= 1'b0;
      olast_q      <= 1'b0;
      ocp_q        <= 1'b0;
      ofin_q       <= 1'b0;
      oerr_q       <= 1'b0;
    end else begin
      if (cfg_we) begin
        hdr_len_q <= pwdata[3:0];
        if (cmd_i.in_hdr) begin
          hdr_left_q <= pwdata[3:0];
        end
      end
      if (in_fire && !done_q && !err_q && !in_i.operation && !held_valid_q) begin
        held_valid_q <= 1'b1;
        held_byte_q  <= in_i.in_byte;
      end
      if (load_out) begin
        ov_q <= 1'b1;
        if (cmd_i.op == DP_STAT) begin
          ob_q    <= pend_valid_q ? pend_byte_q : 8'd0;
          obv_q   <= pend_valid_q;
          olast_q <= 1'b1;
          ocp_q   <= !done_q && !err_q && ((copy_q != 32'd0) || held_valid_q || cmd_i.zero_ph);
          ofin_q  <= done_q;
          oerr_q  <= err_q;
        end else begin
          ob_q    <= pend_byte_q;
          obv_q   <= 1'b1;
          olast_q <= 1'b0;
          ocp_q   <= 1'b0;
          ofin_q  <= 1'b0;
          oerr_q  <= 1'b0;
        end
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      if (emit_en) begin
        wp_q         <= wp_q + 1'b1;
        pend_byte_q  <= emit_b;
        pend_valid_q <= 1'b1;
        if (prod_q != CNT_BITS'(WINDOW_SIZE)) begin
          prod_q <= prod_q + 1'b1;
        end
      end
      if (bit_op) begin
        if (bits_left_q == 4'd0) begin
          tag_q        <= {held_byte_q[6:0], 1'b0};
          bits_left_q  <= 4'd7;
          held_valid_q <= 1'b0;
        end else begin
          tag_q       <= {tag_q[6:0], 1'b0};
          bits_left_q <= bits_left_q - 1'b1;
        end
      end
      case (cmd_i.op)
        DP_HDR: begin
          hdr_left_q   <= hdr_left_q - 1'b1;
          held_valid_q <= 1'b0;
        end
        DP_FIRST: held_valid_q <= 1'b0;
        DP_LIT: begin
          held_valid_q <= 1'b0;
          am_q         <= 1'b0;
        end
        DP_ZERO: am_q <= 1'b0;
        DP_CPY:  copy_q <= copy_q - 1'b1;
        DP_SEVEN: begin
          held_valid_q <= 1'b0;
          mo_q         <= CNT_BITS'(sev_off);
          prev_q       <= CNT_BITS'(sev_off);
          prev_set_q   <= 1'b1;
          copy_q       <= {30'd0, 1'b1, held_byte_q[0]};
          am_q         <= 1'b1;
        end
        DP_LOW: begin
          held_valid_q <= 1'b0;
          mo_q         <= low_off;
          prev_q       <= low_off;
          prev_set_q   <= 1'b1;
          gamma_q      <= 32'd1;
        end
        DP_BIT_MO1:  mo_q <= CNT_BITS'(1);
        DP_BIT_MOSH: mo_q <= {mo_q[CNT_BITS-2:0], bit_val};
        DP_BIT_SHORT: begin
          mo_q   <= CNT_BITS'(short_low);
          copy_q <= 32'd1;
          am_q   <= 1'b0;
        end
        DP_BIT_G1:  gamma_q <= 32'd1;
        DP_BIT_GAM: gamma_q <= {gamma_q[30:0], bit_val};
        DP_BIT_REP: begin
          mo_q    <= prev_q;
          gamma_q <= 32'd1;
        end
        DP_BIT_RG: begin
          copy_q  <= gamma_q;
          gamma_q <= 32'd1;
          am_q    <= 1'b1;
        end
        DP_BIT_LG: begin
          copy_q  <= len32;
          gamma_q <= 32'd1;
          am_q    <= 1'b1;
        end
        DP_FAIL: begin
          err_q        <= 1'b1;
          copy_q       <= '0;
          held_valid_q <= 1'b0;
        end
        DP_DONE: begin
          done_q       <= 1'b1;
          held_valid_q <= 1'b0;
        end
        DP_STAT: pend_valid_q <= 1'b0;
        default: ;
      endcase
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.out_byte     = ob_q;
  assign out_o.byte_valid   = obv_q;
  assign out_o.last         = olast_q;
  assign out_o.copy_pending = ocp_q;
  assign out_o.finished     = ofin_q;
  assign out_o.error_flag   = oerr_q;

endmodule

>>> hw/rtl/lzg_ctrl.sv
// Controller: item sequencer and decode phase state machine; issues one
// datapath opcode per cycle. Depends on lzg_pkg.
module lzg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  lzg_pkg::lzg_stat_t stat_i,
  output lzg_pkg::lzg_cmd_t  cmd_o
);
  import lzg_pkg::*;

  typedef enum logic [3:0] {
    SQ_IDLE = 4'b0001,
    SQ_RUN  = 4'b0010,
    SQ_CPY  = 4'b0100,
    SQ_STAT = 4'b1000
  } seq_e;

  typedef enum logic [15:0] {
    PH_HDR     = 16'h0001,
    PH_FIRST   = 16'h0002,
    PH_TOP     = 16'h0004,
    PH_B2      = 16'h0008,
    PH_B3      = 16'h0010,
    PH_SHORT   = 16'h0020,
    PH_ZERO    = 16'h0040,
    PH_SEVEN   = 16'h0080,
    PH_LIT     = 16'h0100,
    PH_G1_BIT  = 16'h0200,
    PH_G1_CONT = 16'h0400,
    PH_LOW     = 16'h0800,
    PH_RG_BIT  = 16'h1000,
    PH_RG_CONT = 16'h2000,
    PH_LG_BIT  = 16'h4000,
    PH_LG_CONT = 16'h8000
  } phase_e;

  seq_e                seq_q, seq_d;
  phase_e              ph_q, ph_d;
  logic [RUN_BITS-1:0] nres_q, nres_d;
  dp_op_e              op;
  logic                at_cap, inc;

  assign at_cap = nres_q == RUN_BITS'(MAX_RUN);

  always_comb begin
    seq_d = seq_q;
    ph_d  = ph_q;
    op    = DP_NOP;
    inc   = 1'b0;
    case (seq_q)
      SQ_IDLE: begin
        if (in_valid_i) seq_d = SQ_RUN;
      end
      SQ_CPY: begin
        if (stat_i.emit_ok) begin
          op    = DP_CPY;
          inc   = 1'b1;
          seq_d = SQ_RUN;
        end
      end
      SQ_STAT: begin
        if (stat_i.emit_ok) begin
          op    = DP_STAT;
          seq_d = SQ_IDLE;
        end
      end
      SQ_RUN: begin
        if (stat_i.done || stat_i.err) begin
          seq_d = SQ_STAT;
        end else if (stat_i.copy_nz) begin
          if (at_cap) seq_d = SQ_STAT;
          else begin
            op    = DP_RD;
            seq_d = SQ_CPY;
          end
        end else begin
          case (ph_q)
            PH_HDR: begin
              if (stat_i.hdr_zero) ph_d = PH_FIRST;
              else if (!stat_i.held_valid) seq_d = SQ_STAT;
              else op = DP_HDR;
            end
            PH_FIRST, PH_LIT: begin
              if (!stat_i.held_valid || at_cap) seq_d = SQ_STAT;
              else if (stat_i.emit_ok) begin
                op   = (ph_q == PH_LIT) ? DP_LIT : DP_FIRST;
                inc  = 1'b1;
                ph_d = PH_TOP;
              end
            end
            PH_ZERO: begin
              if (at_cap) seq_d = SQ_STAT;
              else if (stat_i.emit_ok) begin
                op   = DP_ZERO;
                inc  = 1'b1;
                ph_d = PH_TOP;
              end
            end
            PH_SEVEN: begin
              if (!stat_i.held_valid) seq_d = SQ_STAT;
              else if (stat_i.sev_zero) begin
                op    = DP_DONE;
                seq_d = SQ_STAT;
              end else if (stat_i.sev_bad) begin
                op    = DP_FAIL;
                seq_d = SQ_STAT;
              end else begin
                op   = DP_SEVEN;
                ph_d = PH_TOP;
              end
            end
            PH_LOW: begin
              if (!stat_i.held_valid) seq_d = SQ_STAT;
              else if (stat_i.low_bad) begin
                op    = DP_FAIL;
                seq_d = SQ_STAT;
              end else begin
                op   = DP_LOW;
                ph_d = PH_LG_BIT;
              end
            end
            default: begin
              if (!stat_i.tag_avail) seq_d = SQ_STAT;
              else begin
                case (ph_q)
                  PH_TOP: begin
                    op   = DP_BIT;
                    ph_d = stat_i.bit_val ? PH_B2 : PH_LIT;
                  end
                  PH_B2: begin
                    op   = stat_i.bit_val ? DP_BIT : DP_BIT_G1;
                    ph_d = stat_i.bit_val ? PH_B3 : PH_G1_BIT;
                  end
                  PH_B3: begin
                    op   = stat_i.bit_val ? DP_BIT_MO1 : DP_BIT;
                    ph_d = stat_i.bit_val ? PH_SHORT : PH_SEVEN;
                  end
                  PH_SHORT: begin
                    if (!stat_i.short_full) op = DP_BIT_MOSH;
                    else if (stat_i.short_zero) begin
                      op   = DP_BIT;
                      ph_d = PH_ZERO;
                    end else if (stat_i.short_bad) begin
                      op    = DP_FAIL;
                      seq_d = SQ_STAT;
                    end else begin
                      op   = DP_BIT_SHORT;
                      ph_d = PH_TOP;
                    end
                  end
                  PH_G1_BIT, PH_RG_BIT, PH_LG_BIT: begin
                    if (stat_i.g_msb) begin
                      op    = DP_FAIL;
                      seq_d = SQ_STAT;
                    end else begin
                      op = DP_BIT_GAM;
                      case (ph_q)
                        PH_G1_BIT: ph_d = PH_G1_CONT;
                        PH_RG_BIT: ph_d = PH_RG_CONT;
                        default:   ph_d = PH_LG_CONT;
                      endcase
                    end
                  end
                  PH_G1_CONT: begin
                    if (stat_i.bit_val) begin
                      op   = DP_BIT;
                      ph_d = PH_G1_BIT;
                    end else if (!stat_i.after_match && stat_i.g_is2) begin
                      if (stat_i.prev_bad) begin
                        op    = DP_FAIL;
                        seq_d = SQ_STAT;
                      end else begin
                        op   = DP_BIT_REP;
                        ph_d = PH_RG_BIT;
                      end
                    end else begin
                      op   = DP_BIT;
                      ph_d = PH_LOW;
                    end
                  end
                  PH_RG_CONT: begin
                    op   = stat_i.bit_val ? DP_BIT : DP_BIT_RG;
                    ph_d = stat_i.bit_val ? PH_RG_BIT : PH_TOP;
                  end
                  PH_LG_CONT: begin
                    op   = stat_i.bit_val ? DP_BIT : DP_BIT_LG;
                    ph_d = stat_i.bit_val ? PH_LG_BIT : PH_TOP;
                  end
                  default: begin
                    op    = DP_FAIL;
                    seq_d = SQ_STAT;
                  end
                endcase
              end
            end
          endcase
        end
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  always_comb begin
    nres_d = nres_q;
    if (seq_q == SQ_IDLE && in_valid_i) nres_d = '0;
    else if (inc) nres_d = nres_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= SQ_IDLE;
      ph_q   <= PH_HDR;
      nres_q <= '0;
    end else begin
      seq_q  <= seq_d;
      ph_q   <= ph_d;
      nres_q <= nres_d;
    end
  end

  assign cmd_o.op       = op;
  assign cmd_o.in_ready = seq_q == SQ_IDLE;
  assign cmd_o.zero_ph  = ph_q == PH_ZERO;
  assign cmd_o.in_hdr   = ph_q == PH_HDR;

endmodule

>>> hw/rtl/lz_gamma_stream_decompressor.sv
// Top level of the LZ gamma stream decompressor: controller plus datapath.
// Depends on lzg_pkg, lzg_if, lzg_ctrl and lzg_datapath.
//
// Usage: in_i takes one word per item: operation 0 pushes in_byte, operation 1
// continues a pending copy. out_o returns one or more words per item; the
// final word has last set and carries copy_pending, finished and error_flag.
// If the item emits no byte, a single word with byte_valid 0 is returned.
// Items are processed one at a time; in_i.ready is high only between items.
// Each item is accepted, then decoded in steps: a step per tag bit, header
// byte, offset byte, literal or zero byte, a step to leave the header phase,
// and for each copied byte a history read, then a write; a step finds the
// item used up and a final step sends the last word. The single-port
// history window sets the copy rate. At most 64 bytes leave per item.
// When out_o is stalled the block holds in its emit step; one word waits in a
// staging register and one in the output register.
// Reset clears all control state and loads header_length with 8; the history
// window needs no clearing. The APB register header_length sits at address 0.
module lz_gamma_stream_decompressor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lzg_in_if.sink                         in_i,
  lzg_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lzg_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import lzg_pkg::*;

  lzg_cmd_t  cmd;
  lzg_stat_t stat;

  lzg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lzg_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .in_i    (in_i),
    .out_o   (out_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  a_mid_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.last |-> out_o.byte_valid)
    else $error("non-final word without a byte");

  a_mid_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.last |-> !out_o.copy_pending && !out_o.finished && !out_o.error_flag)
    else $error("status on non-final word");

  a_end_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.finished || out_o.error_flag) |-> !out_o.copy_pending)
    else $error("copy pending after stop");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("accepted two items back to back");

endmodule
